// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the lag generator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Antecedent true in a cycle implies the consequent in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent true in a cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/cmwc_pkg.sv =====
// Constants and helper functions of the CMWC random word generator.
// No dependencies; imported by the generator top level and the testbench.
package cmwc_pkg;

	// Action codes carried in the input tuser bit.
	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	// Register word index of the size code.
	localparam logic REG_SIZE_CODE = 1'b0;

	localparam logic [3:0]  SIZE_CODE_RESET = 4'd8;
	localparam logic [3:0]  SIZE_CODE_MAX   = 4'd8;
	localparam logic [31:0] CARRY_INIT      = 32'd362436;
	localparam logic [31:0] CMWC_R          = 32'hffff_fffe;
	// Log2 of the largest lag in the table.
	localparam int          LAG_LOG2_TOP    = 12;

	// Codes above the table top behave as the top code.
	function automatic logic [3:0] code_sel(input logic [3:0] code);
		return (code > SIZE_CODE_MAX) ? SIZE_CODE_MAX : code;
	endfunction

	// Multiplier for each size code.
	function automatic logic [31:0] mult_of(input logic [3:0] code);
		logic [31:0] m;
		unique case (code_sel(code))
			4'd0:    m = 32'd716514398;
			4'd1:    m = 32'd487198574;
			4'd2:    m = 32'd547416522;
			4'd3:    m = 32'd647535442;
			4'd4:    m = 32'd8007626;
			4'd5:    m = 32'd8001634;
			4'd6:    m = 32'd123554632;
			4'd7:    m = 32'd123471786;
			default: m = 32'd18782;
		endcase
		return m;
	endfunction

	// Log2 of the table lag for each size code (8 up to 4096).
	function automatic logic [3:0] lag_log2_of(input logic [3:0] code);
		logic [3:0] l;
		unique case (code_sel(code))
			4'd0:    l = 4'd3;
			4'd1:    l = 4'd4;
			4'd2:    l = 4'd5;
			4'd3:    l = 4'd6;
			4'd4:    l = 4'd7;
			4'd5:    l = 4'd8;
			4'd6:    l = 4'd9;
			4'd7:    l = 4'd10;
			default: l = 4'd12;
		endcase
		return l;
	endfunction

	// One step of the 13/17/5 xorshift used to fill the lag store.
	function automatic logic [31:0] xs_next(input logic [31:0] j);
		logic [31:0] a;
		logic [31:0] b;
		a = j ^ (j << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

// ===== rtl/core/cmwc_ram.sv =====
// Generic single-port RAM with a registered read.
// No dependencies; holds the lag store of the generator.
module cmwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read at the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/core/cmwc_random_generator.sv =====
// Top level of the CMWC random word generator: sequencer, arithmetic and ports.
// Depends on cmwc_pkg, cmwc_ram and assert_macros.svh.
//
// A seed transaction (tuser = 0, tdata = seed word) fills the first lag entries
// of the lag store with a 13/17/5 xorshift sequence, one entry per cycle, then
// resets the carry to 362436 and the index to lag-1; it returns nothing and
// holds s_tready low until the fill is done. A draw transaction (tuser = 1)
// returns one 32-bit word: the lag RAM is read at the accepting edge, then the
// MUL, ADD and FIN states do the 32x32 multiply, the 64-bit carry add, and the
// finishing of the word and its write back; the next item is taken in the cycle
// after the write back, so draws do not overlap, and FIN waits while the output
// is stalled. The lag and multiplier come from the size code register at
// address 0 (reset 8, lag 4096); change it only while the block is idle, and
// reseed after a change to get a fresh sequence. Draws before the first seed
// return undefined words.
module cmwc_random_generator #(
	parameter int MAX_LAG = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] seed_value
	input  logic        s_tuser,  // [0] action
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] random_word
);

	import cmwc_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W          = $clog2(MAX_LAG);
	localparam int LAG_LOG2_MAX   = $clog2(MAX_LAG + 1) - 1;
	localparam int RESET_LOG2     = (LAG_LOG2_MAX < LAG_LOG2_TOP) ? LAG_LOG2_MAX
		: LAG_LOG2_TOP;
	localparam logic [IDX_W-1:0] RESET_IDX = IDX_W'((64'd1 << RESET_LOG2) - 64'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_MUL,
		ST_ADD,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [3:0]        size_code_q;
	logic [31:0]       carry_q;
	logic [IDX_W-1:0]  lag_index_q;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;

	logic [IDX_W-1:0]  seed_idx_q;
	logic [31:0]       seed_j_q;
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       mult_q;
	logic [63:0]       prod_s1;
	logic [63:0]       sum_s2;

	logic [3:0]        eff_log2;
	logic [IDX_W-1:0]  lag_mask;
	logic [IDX_W-1:0]  next_idx;
	logic [31:0]       seed_j_next;
	logic [32:0]       fin_sum;
	logic              fin_ovf;
	logic [31:0]       fin_x;
	logic [31:0]       fin_carry;
	logic [31:0]       fin_word;
	logic              out_free;
	logic              in_fire;
	logic              cfg_write;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [31:0]       ram_wdata;
	logic [31:0]       ram_rdata;

	// Effective lag: table lag clipped to the store depth.
	always_comb begin
		eff_log2 = lag_log2_of(size_code_q);
		if (32'(eff_log2) > LAG_LOG2_MAX) begin
			eff_log2 = 4'(LAG_LOG2_MAX);
		end
		for (int b = 0; b < IDX_W; b++) begin
			lag_mask[b] = (5'(b) < {1'b0, eff_log2});
		end
	end

	// Handshakes and next index.
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign next_idx  = (lag_index_q + IDX_W'(1)) & lag_mask;
	assign cfg_write = psel && penable && pwrite && pready;

	// Seed fill step.
	assign seed_j_next = xs_next(seed_j_q);

	// Final carry correction and complement.
	always_comb begin
		fin_sum   = {1'b0, sum_s2[31:0]} + {1'b0, sum_s2[63:32]};
		fin_ovf   = fin_sum[32];
		fin_x     = fin_sum[31:0] + {31'b0, fin_ovf};
		fin_carry = sum_s2[63:32] + {31'b0, fin_ovf};
		fin_word  = CMWC_R - fin_x;
	end

	// Lag RAM port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = fin_word;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = next_idx;
			end
			ST_SEED: begin
				ram_we    = 1'b1;
				ram_addr  = seed_idx_q;
				ram_wdata = seed_j_next;
			end
			ST_FIN: begin
				ram_we = out_free;
			end
			default: begin
				ram_addr = idx_q;
			end
		endcase
	end

	cmwc_ram #(
		.WIDTH(32),
		.DEPTH(MAX_LAG)
	) u_lag_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Sequencer with control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_code_q <= SIZE_CODE_RESET;
			carry_q     <= CARRY_INIT;
			lag_index_q <= RESET_IDX;
			m_tvalid_q  <= 1'b0;
			seed_idx_q  <= '0;
		end else begin
			// A finishing draw refills the output in the cycle it drains.
			if (m_tvalid_q && m_tready && !(state_q == ST_FIN && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_write && paddr[2] == REG_SIZE_CODE) begin
				size_code_q <= pwdata[3:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == ACT_SEED) begin
							seed_idx_q <= '0;
							state_q    <= ST_SEED;
						end else begin
							lag_index_q <= next_idx;
							state_q     <= ST_MUL;
						end
					end
				end
				ST_SEED: begin
					if (seed_idx_q == lag_mask) begin
						carry_q     <= CARRY_INIT;
						lag_index_q <= lag_mask;
						state_q     <= ST_IDLE;
					end else begin
						seed_idx_q <= seed_idx_q + IDX_W'(1);
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						carry_q    <= fin_carry;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			seed_j_q <= s_tdata;
			idx_q    <= next_idx;
			mult_q   <= mult_of(size_code_q);
		end else if (state_q == ST_SEED) begin
			seed_j_q <= seed_j_next;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= {32'b0, mult_q} * {32'b0, ram_rdata};
		end
		if (state_q == ST_ADD) begin
			sum_s2 <= prod_s1 + {32'b0, carry_q};
		end
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= fin_word;
		end
	end

	// Configuration read back.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIZE_CODE) ? {28'b0, size_code_q} : 32'b0;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_NEXT(a_seed_starts, clk, arst_n, in_fire && s_tuser == ACT_SEED,
		state_q == ST_SEED)
	`ASSERT_NEXT(a_draw_starts, clk, arst_n, in_fire && s_tuser == ACT_DRAW,
		state_q == ST_MUL && lag_index_q == idx_q)
	`ASSERT_IMP(a_seed_in_lag, clk, arst_n, state_q == ST_SEED,
		(seed_idx_q & ~lag_mask) == '0)
	`ASSERT_IMP(a_ram_write_src, clk, arst_n, ram_we,
		state_q == ST_SEED || state_q == ST_FIN)
	`ASSERT_NEXT(a_fin_result, clk, arst_n, state_q == ST_FIN && out_free,
		m_tvalid_q && state_q == ST_IDLE)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the CMWC random word generator: seeds and draws are streamed in,
// each drawn word is predicted in the bench and compared with the block's output.
// Depends on cmwc_pkg and the cmwc_random_generator RTL; reads no files.
module testbench;
	import cmwc_pkg::*;

	localparam int unsigned LAG_TOP = 4096;
	localparam logic [2:0] SIZE_CODE_ADDR = 3'(4 * REG_SIZE_CODE);
	localparam int unsigned MAX_PRINTED = 100;

	// One pending request for the input stream.
	typedef struct {
		logic act;
		logic [31:0] seed;
		bit hold;
	} rng_request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;  // [31:0] seed_value
	logic s_tuser = 1'b0;       // [0] action
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;       // [31:0] random_word

	// Bench copy of the generator state and the size code.
	logic [31:0] lag_words [0:LAG_TOP-1];
	logic [31:0] carry_now;
	logic [11:0] index_now;
	logic [3:0] code_now;

	rng_request_t request_q[$];
	logic [31:0] word_q[$];
	int unsigned seeded_extent;
	int unsigned mismatch_count = 0;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	bit quiet = 1'b0;

	cmwc_random_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Codes above eight select the largest lag.
	function automatic int unsigned lag_of(input logic [3:0] code);
		return (code >= 4'd8) ? LAG_TOP : (32'd8 << code);
	endfunction

	function automatic logic [31:0] multiplier_of(input logic [3:0] code);
		case (code)
			4'd0: return 32'd716514398;
			4'd1: return 32'd487198574;
			4'd2: return 32'd547416522;
			4'd3: return 32'd647535442;
			4'd4: return 32'd8007626;
			4'd5: return 32'd8001634;
			4'd6: return 32'd123554632;
			4'd7: return 32'd123471786;
			default: return 32'd18782;
		endcase
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 87)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_seed();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'h0000_0000;
		if (roll == 1)
			return 32'hffff_ffff;
		if (roll == 2)
			return 32'h1 << $urandom_range(0, 31);
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Apply one accepted transaction to the bench state; a draw queues its word.
	task automatic advance_generator(input logic act, input logic [31:0] seed);
		int unsigned lag;
		logic [31:0] j;
		logic [11:0] idx;
		logic [63:0] t;
		logic [31:0] x;
		lag = lag_of(code_now);
		if (act == ACT_SEED) begin
			j = seed;
			for (int unsigned i = 0; i < lag; i++) begin
				j = j ^ (j << 13);
				j = j ^ (j >> 17);
				j = j ^ (j << 5);
				lag_words[i] = j;
			end
			carry_now = CARRY_INIT;
			index_now = 12'(lag - 1);
		end else begin
			idx = (index_now + 12'd1) & 12'(lag - 1);
			index_now = idx;
			t = 64'(multiplier_of(code_now)) * 64'(lag_words[idx]) + 64'(carry_now);
			carry_now = t[63:32];
			x = t[31:0] + carry_now;
			// Overflow of the carry add wraps around with a correction of one.
			if (x < carry_now) begin
				x = x + 32'd1;
				carry_now = carry_now + 32'd1;
			end
			lag_words[idx] = CMWC_R - x;
			word_q.push_back(CMWC_R - x);
		end
	endtask

	// Writes the size code, then reads it back.
	task automatic write_size_code(input logic [3:0] code);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SIZE_CODE_ADDR;
		pwdata <= {28'($urandom), code};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		code_now = code;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[3:0] !== code)
			report_mismatch($sformatf("size code read back %0h, written %0h", prdata[3:0], code));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_request(input logic act, input logic [31:0] seed, input bit hold);
		rng_request_t r;
		r.act = act;
		r.seed = seed;
		r.hold = hold;
		request_q.push_back(r);
		if (act == ACT_SEED && lag_of(code_now) > seeded_extent)
			seeded_extent = lag_of(code_now);
	endtask

	task automatic push_draws(input int unsigned count);
		for (int unsigned k = 0; k < count; k++)
			push_request(ACT_DRAW, $urandom, 1'b0);
	endtask

	// Waits until every request is sent and every word is back, then lets a seed fill finish.
	task automatic wait_idle();
		while (request_q.size() != 0 || s_tvalid || word_q.size() != 0)
			@(posedge clk);
		repeat (lag_of(code_now) + 16) @(posedge clk);
	endtask

	// Input driver: presents queued requests, with random gaps after each transaction.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		int unsigned gap_now;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= ACT_SEED;
			send_gap <= 0;
		end else begin
			gap_now = send_gap;
			if (s_tvalid && s_tready) begin
				advance_generator(s_tuser, s_tdata);
				gap_now = quiet ? 0 : pick_gap();
			end
			if (!s_tvalid || s_tready) begin
				if (gap_now != 0) begin
					s_tvalid <= 1'b0;
					send_gap <= gap_now - 1;
				end else if (request_q.size() != 0 &&
						(!request_q[0].hold || (!s_tvalid && word_q.size() == 0))) begin
					s_tvalid <= 1'b1;
					s_tuser <= request_q[0].act;
					s_tdata <= request_q[0].seed;
					request_q.pop_front();
					send_gap <= 0;
				end else begin
					s_tvalid <= 1'b0;
					send_gap <= 0;
				end
			end
		end
	end

	// Output monitor: checks each word against the oldest prediction, stalls at random.
	always @(posedge clk or negedge arst_n) begin : receive_proc
		logic [31:0] want;
		int unsigned stall_len;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (word_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word %08h", m_tdata));
				end else begin
					want = word_q.pop_front();
					if (m_tdata !== want)
						report_mismatch($sformatf("random_word %08h, predicted %08h",
							m_tdata, want));
				end
			end
			if (quiet) begin
				m_tready <= 1'b1;
				recv_stall <= 0;
			end else if (recv_stall != 0) begin
				m_tready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				stall_len = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
				if (stall_len != 0) begin
					m_tready <= 1'b0;
					recv_stall <= stall_len - 1;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Stimulus: a directed part, then random phases, each under its own size code.
	initial begin : stimulus
		int unsigned random_items;
		int unsigned phase_len;
		int unsigned roll;
		logic [3:0] code;
		for (int i = 0; i < LAG_TOP; i++)
			lag_words[i] = '0;
		code_now = SIZE_CODE_RESET;
		carry_now = CARRY_INIT;
		index_now = 12'(lag_of(SIZE_CODE_RESET) - 1);
		seeded_extent = 0;
		random_items = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest lag: an all-zero seed, then an all-ones seed with draws past the wrap.
		write_size_code(4'd0);
		push_request(ACT_SEED, 32'h0000_0000, 1'b0);
		push_draws(3);
		push_request(ACT_SEED, 32'hffff_ffff, 1'b0);
		push_draws(4);
		push_request(ACT_DRAW, 32'hffff_ffff, 1'b1);
		push_draws(4);
		wait_idle();

		// A code above eight acts as the largest lag.
		write_size_code(4'd15);
		push_request(ACT_SEED, pick_seed(), 1'b0);
		push_draws(2);
		wait_idle();

		// Size changes without reseed keep the store; the index is masked to the new lag.
		write_size_code(4'd3);
		push_draws(4);
		wait_idle();
		write_size_code(4'd8);
		push_draws(2);

		// Random phases.
		while (random_items < 925) begin
			wait_idle();
			roll = $urandom_range(0, 99);
			if (roll < 70)
				code = 4'($urandom_range(0, 4));
			else if (roll < 92)
				code = 4'($urandom_range(5, 7));
			else
				code = 4'($urandom_range(8, 15));
			quiet = ($urandom_range(0, 4) == 0);
			write_size_code(code);
			if (lag_of(code) > seeded_extent || $urandom_range(0, 2) != 0) begin
				push_request(ACT_SEED, pick_seed(), $urandom_range(0, 3) == 0);
				random_items++;
			end
			phase_len = $urandom_range(30, 100);
			for (int unsigned k = 0; k < phase_len; k++) begin
				if (lag_of(code) < 1024 && $urandom_range(0, 24) == 0)
					push_request(ACT_SEED, pick_seed(), $urandom_range(0, 7) == 0);
				else
					push_request(ACT_DRAW, $urandom, $urandom_range(0, 39) == 0);
				random_items++;
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Run limit.
	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== cmwc_random_generator.f =====
+incdir+rtl/core
rtl/core/cmwc_pkg.sv
rtl/core/cmwc_ram.sv
rtl/core/cmwc_random_generator.sv
tb/sv/testbench.sv
